>>> rtl/core/crank_24x_angle_decoder_defines.svh
// Assertion macros shared by the crank decoder modules.
`ifndef CRANK_24X_ANGLE_DECODER_DEFINES_SVH
`define CRANK_24X_ANGLE_DECODER_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define CAD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Asserts that an antecedent implies a consequent in the next cycle.
`define CAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cad_pkg.sv
// Package with item types, sequencer codes and the base angle table of the crank decoder.
package cad_pkg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] tick;
        logic        level;
    } in_item_t;

    typedef struct packed {
        logic [15:0] angle_q7;
        logic        angle_valid;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend_hi;
        logic [31:0] dividend_lo;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    localparam logic REQ_EDGE  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [31:0] HALF_RANGE   = 32'h8000_0000;
    localparam logic [31:0] ILLEGAL_MASK = 32'h0464_2A10;
    localparam logic [15:0] ANGLE_MAX    = 16'hFFFF;

    function automatic logic [8:0] base_angle(input logic [4:0] pat, input logic lvl);
        logic [8:0] b0;
        logic [8:0] b1;
        begin
            unique case (pat)
                5'd0:  begin b0 = 9'd15;  b1 = 9'd18;  end
                5'd1:  begin b0 = 9'd0;   b1 = 9'd12;  end
                5'd2:  begin b0 = 9'd345; b1 = 9'd357; end
                5'd3:  begin b0 = 9'd255; b1 = 9'd258; end
                5'd5:  begin b0 = 9'd330; b1 = 9'd342; end
                5'd6:  begin b0 = 9'd240; b1 = 9'd252; end
                5'd7:  begin b0 = 9'd180; b1 = 9'd183; end
                5'd8:  begin b0 = 9'd285; b1 = 9'd288; end
                5'd10: begin b0 = 9'd315; b1 = 9'd327; end
                5'd12: begin b0 = 9'd225; b1 = 9'd237; end
                5'd14: begin b0 = 9'd165; b1 = 9'd177; end
                5'd15: begin b0 = 9'd105; b1 = 9'd108; end
                5'd16: begin b0 = 9'd30;  b1 = 9'd33;  end
                5'd17: begin b0 = 9'd270; b1 = 9'd282; end
                5'd19: begin b0 = 9'd195; b1 = 9'd198; end
                5'd20: begin b0 = 9'd300; b1 = 9'd312; end
                5'd23: begin b0 = 9'd120; b1 = 9'd123; end
                5'd24: begin b0 = 9'd45;  b1 = 9'd48;  end
                5'd25: begin b0 = 9'd210; b1 = 9'd222; end
                5'd27: begin b0 = 9'd135; b1 = 9'd138; end
                5'd28: begin b0 = 9'd60;  b1 = 9'd63;  end
                5'd29: begin b0 = 9'd150; b1 = 9'd162; end
                5'd30: begin b0 = 9'd75;  b1 = 9'd78;  end
                5'd31: begin b0 = 9'd90;  b1 = 9'd102; end
                default: begin b0 = 9'd0; b1 = 9'd0; end
            endcase
            base_angle = lvl ? b1 : b0;
        end
    endfunction

    // Since 16 and 256 are both 1 modulo 15, summing hex digits keeps the residue.
    function automatic logic [3:0] pulse_deg(input logic [8:0] base, input logic first_long);
        logic [4:0] s;
        logic [4:0] f;
        logic [4:0] r;
        begin
            s = {1'b0, base[3:0]} + {1'b0, base[7:4]} + {4'b0000, base[8]};
            f = {1'b0, s[3:0]} + {4'b0000, s[4]};
            r = (f >= 5'd15) ? f - 5'd15 : f;
            if (r == 5'd0)
            begin
                pulse_deg = first_long ? 4'd12 : 4'd3;
            end
            else
            begin
                pulse_deg = r[3:0];
            end
        end
    endfunction

endpackage

>>> rtl/core/cad_divider.sv
// Restoring divider that produces a 64-bit quotient one bit per cycle.
module cad_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  cad_pkg::div_req_t req,
    output cad_pkg::div_rsp_t rsp
);
    `include "crank_24x_angle_decoder_defines.svh"

    logic [63:0] quot_reg;
    logic [63:0] quot_next;
    logic [32:0] rem_reg;
    logic [32:0] rem_next;
    logic [31:0] dsor_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [32:0] trial;
    logic [33:0] diff;

    always_comb
    begin
        trial = {rem_reg[31:0], quot_reg[63]};
        diff  = {1'b0, trial} - {2'b00, dsor_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quot_next = {req.dividend_hi, req.dividend_lo};
            rem_next  = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_next  = diff[32:0];
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (req.start)
        begin
            dsor_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

    `CAD_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "done held two cycles")
    `CAD_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg, "done while busy")
    `CAD_ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_reg, "start did not set busy")

endmodule

>>> rtl/core/crank_24x_angle_decoder.sv
// Top level of the 24-tooth crank angle decoder: edge ring memory and query sequencer.
//
// Usage: one input channel (in_valid, in_stall, in_data) carries edge and query items.
// An edge item writes the next ring slot and gives no result.
// A query item gives exactly one result item on the output channel (out_valid,
// out_stall, out_data). A query walks back over the ring past each edge that is
// later than the query, reads the anchor and the eleven entries behind it, then
// runs a bit-serial divider. A decoded query passes through S_HEAD, S_WALK, S_HIST,
// S_PREP, S_CALC, S_DIV and S_RESULT, where its result is registered; failed queries
// end sooner in S_FAIL. The next item can be accepted once the result is registered
// and the sequencer is back in S_IDLE. Ring reads and the serial divider set the pace.
// Items are taken one at a time; in_stall is high while an item is in work.
// The result waits in an output register; while out_stall is high the next item
// may still be accepted and processed up to the point where its own result is ready.
// Reset clears the ring valid bits and the head pointer; no clearing pass is needed.
// Unwritten ring entries may be read: only the anchor and eighth older entry are checked.
module crank_24x_angle_decoder #(
    parameter int RING_DEPTH = 16,
    parameter int FRAC_BITS  = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cad_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cad_pkg::out_item_t   out_data
);
    `include "crank_24x_angle_decoder_defines.svh"

    localparam int IW = $clog2(RING_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EDGE   = 4'd1;
    localparam logic [3:0] S_HEAD   = 4'd2;
    localparam logic [3:0] S_WALK   = 4'd3;
    localparam logic [3:0] S_HIST   = 4'd4;
    localparam logic [3:0] S_CALC   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_RESULT = 4'd7;
    localparam logic [3:0] S_FAIL   = 4'd8;
    localparam logic [3:0] S_PREP   = 4'd9;

    logic [31:0] mem_time [RING_DEPTH];
    logic        mem_level [RING_DEPTH];
    logic [RING_DEPTH-1:0] valid_reg;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [IW-1:0] head_inc;
    logic        edge_fire;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic [31:0] tick_reg;
    logic [IW-1:0] addr_reg;
    logic [IW-1:0] addr_next;
    logic [IW-1:0] anchor_reg;
    logic [IW-1:0] anchor_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic        rd_en;
    logic [31:0] rd_time_reg;
    logic        rd_level_reg;
    logic        rd_pend_reg;
    logic [31:0] hist_t_reg [12];
    logic        hist_l_reg [12];
    logic        hist_v8_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    cad_pkg::out_item_t out_reg;
    cad_pkg::out_item_t out_next;

    cad_pkg::div_req_t div_req;
    cad_pkg::div_rsp_t div_rsp;
    logic [8:0]  base_reg;
    logic        calc_ok_reg;
    logic [31:0] ivl_reg;
    logic [35:0] prod_reg;

    logic [4:0]  pat;
    logic [8:0]  base_c;
    logic [3:0]  pd_c;
    logic [31:0] ivl_c;
    logic [31:0] elap_c;
    logic        in_fire;
    logic [64:0] sum_c;

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] a);
        begin
            ring_inc = (a == IW'(RING_DEPTH - 1)) ? '0 : a + IW'(1);
        end
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] a);
        begin
            ring_dec = (a == '0) ? IW'(RING_DEPTH - 1) : a - IW'(1);
        end
    endfunction

    function automatic logic is_long(input logic [3:0] k);
        logic [3:0]  f;
        logic [31:0] per;
        logic [31:0] hi;
        begin
            f = k;
            if (hist_l_reg[f])
            begin
                f = f + 4'd1;
            end
            per = hist_t_reg[f] - hist_t_reg[f + 4'd2];
            hi  = hist_t_reg[f] - hist_t_reg[f + 4'd1];
            is_long = hi > {1'b0, per[31:1]};
        end
    endfunction

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign head_inc  = ring_inc(head_reg);
    assign edge_fire = in_fire && in_data.req_type == cad_pkg::REQ_EDGE;

    always_ff @(posedge clk)
    begin
        if (edge_fire)
        begin
            mem_time[head_inc]  <= in_data.tick;
            mem_level[head_inc] <= in_data.level;
        end
        if (rd_en)
        begin
            rd_time_reg  <= mem_time[addr_next];
            rd_level_reg <= mem_level[addr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            head_reg    <= '0;
            state_reg   <= S_IDLE;
            out_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (edge_fire)
            begin
                valid_reg[head_inc] <= 1'b1;
            end
            head_reg      <= head_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_en;
        end
    end

    always_comb
    begin
        pat = {is_long(4'd0), is_long(4'd2), is_long(4'd4), is_long(4'd6), is_long(4'd8)};
        base_c = cad_pkg::base_angle(pat, hist_l_reg[0]);
        pd_c   = cad_pkg::pulse_deg(base_c, pat[4]);
        ivl_c  = hist_t_reg[0] - hist_t_reg[1];
        elap_c = tick_reg - hist_t_reg[0];
        sum_c  = {1'b0, div_rsp.quotient} + (65'(base_reg) << FRAC_BITS);
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        addr_next   = addr_reg;
        anchor_next = anchor_reg;
        cnt_next    = cnt_reg;
        rd_en       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_next    = out_reg;
        div_req.start       = 1'b0;
        div_req.dividend_hi = 32'(prod_reg >> (32 - FRAC_BITS));
        div_req.dividend_lo = 32'(prod_reg << FRAC_BITS);
        div_req.divisor     = ivl_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.req_type == cad_pkg::REQ_EDGE)
                    begin
                        head_next  = head_inc;
                        state_next = S_EDGE;
                    end
                    else
                    begin
                        addr_next  = head_reg;
                        rd_en      = 1'b1;
                        state_next = S_HEAD;
                    end
                end
            end
            S_EDGE:
            begin
                state_next = S_IDLE;
            end
            S_HEAD:
            begin
                if (!valid_reg[addr_reg])
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    anchor_next = addr_reg;
                    state_next  = S_WALK;
                end
            end
            S_WALK:
            begin
                if ((tick_reg - rd_time_reg) > cad_pkg::HALF_RANGE)
                begin
                    addr_next = ring_dec(anchor_reg);
                    if (!valid_reg[addr_next] || addr_next == head_reg)
                    begin
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        anchor_next = addr_next;
                        rd_en = 1'b1;
                        state_next = S_HEAD;
                    end
                end
                else
                begin
                    cnt_next  = 4'd0;
                    addr_next = anchor_reg;
                    rd_en     = 1'b1;
                    state_next = S_HIST;
                end
            end
            S_HIST:
            begin
                if (rd_pend_reg)
                begin
                    if (cnt_reg == 4'd11)
                    begin
                        state_next = S_PREP;
                    end
                    else
                    begin
                        cnt_next  = cnt_reg + 4'd1;
                        addr_next = ring_dec(addr_reg);
                        rd_en     = 1'b1;
                    end
                end
            end
            S_PREP:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (!hist_v8_reg || !calc_ok_reg)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next.angle_valid = 1'b1;
                    out_next.angle_q7 = (sum_c > 65'(cad_pkg::ANGLE_MAX))
                        ? cad_pkg::ANGLE_MAX : sum_c[15:0];
                    state_next = S_IDLE;
                end
            end
            S_FAIL:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next.angle_valid = 1'b0;
                    out_next.angle_q7 = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        anchor_reg <= anchor_next;
        cnt_reg    <= cnt_next;
        out_reg    <= out_next;
        if (in_fire)
        begin
            tick_reg <= in_data.tick;
        end
        if (state_reg == S_HIST && rd_pend_reg)
        begin
            hist_t_reg[cnt_reg] <= rd_time_reg;
            hist_l_reg[cnt_reg] <= rd_level_reg;
            if (cnt_reg == 4'd8)
            begin
                hist_v8_reg <= valid_reg[addr_reg];
            end
        end
        if (state_reg == S_CALC)
        begin
            base_reg <= base_c;
        end
        calc_ok_reg <= !cad_pkg::ILLEGAL_MASK[pat] && (ivl_c != 32'd0);
        ivl_reg  <= ivl_c;
        prod_reg <= 36'(elap_c) * 36'(pd_c);
    end

    cad_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CAD_ASSERT_IMP(a_busy_stall, clk, rst_n, state_reg != S_IDLE, in_stall, "item taken while busy")
    `CAD_ASSERT_NEXT(a_edge_head, clk, rst_n, edge_fire, valid_reg[head_reg], "edge slot not valid")
    `CAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && out_stall, out_valid_reg && $stable(out_reg), "result lost under stall")

endmodule

>>> sim/crank_24x_angle_decoder_tb.sv
// Testbench for the 24-tooth crank angle decoder: wheel stimulus, angle prediction and checking.
`timescale 1ns / 1ps

module crank_24x_angle_decoder_tb;

    typedef struct {
        cad_pkg::in_item_t item;
        bit                drain;
    } pending_t;

    localparam int RING_DEPTH = 16;
    localparam int FRAC_BITS  = 7;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic [8:0] BASE_LOW[32] = '{
        15, 0, 345, 255, 0, 330, 240, 180, 285, 0, 315, 0, 225, 0, 165, 105,
        30, 270, 0, 195, 300, 0, 0, 120, 45, 210, 0, 135, 60, 150, 75, 90};
    localparam logic [8:0] BASE_HIGH[32] = '{
        18, 12, 357, 258, 0, 342, 252, 183, 288, 0, 327, 0, 237, 0, 177, 108,
        33, 282, 0, 198, 312, 0, 0, 123, 48, 222, 0, 138, 63, 162, 78, 102};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    cad_pkg::in_item_t  in_data;
    logic       out_valid;
    logic       out_stall;
    cad_pkg::out_item_t out_data;

    pending_t   item_queue[$];
    cad_pkg::out_item_t angle_queue[$];

    logic [31:0] tooth_time[RING_DEPTH];
    logic        tooth_level[RING_DEPTH];
    logic        tooth_seen[RING_DEPTH];
    int          head;

    bit          in_taken;
    bit          out_taken;
    int          gap_cnt;
    int          stall_cnt;
    bit          idle_on;
    int          errors;
    int          cycles;
    int          n_edges;
    int          n_queries;
    int          n_valid;
    int          n_invalid;

    logic [31:0] wheel_now;
    logic [31:0] last_edge;
    int          period;

    crank_24x_angle_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    function automatic int slot_back(int idx, int n);
        return ((idx % RING_DEPTH) + RING_DEPTH - (n % RING_DEPTH)) % RING_DEPTH;
    endfunction

    function automatic bit tooth_is_long(int f);
        logic [31:0] per;
        logic [31:0] hi;
        int          g;
        g = f % RING_DEPTH;
        if (tooth_level[g])
        begin
            g = slot_back(g, 1);
        end
        per = tooth_time[g] - tooth_time[slot_back(g, 2)];
        hi = tooth_time[g] - tooth_time[slot_back(g, 1)];
        return hi > (per >> 1);
    endfunction

    function automatic cad_pkg::out_item_t predict_angle(logic [31:0] tk);
        cad_pkg::out_item_t res;
        int          anchor;
        int          start;
        logic [4:0]  pat;
        logic [8:0]  base;
        logic [3:0]  pd;
        bit          first_long;
        logic [31:0] interval;
        logic [31:0] elapsed;
        logic [63:0] acc;
        res = '0;
        anchor = head;
        if (!tooth_seen[anchor])
        begin
            return res;
        end
        start = anchor;
        while ((tk - tooth_time[anchor]) > cad_pkg::HALF_RANGE)
        begin
            anchor = slot_back(anchor, 1);
            if (!tooth_seen[anchor] || anchor == start)
            begin
                return res;
            end
        end
        if (!tooth_seen[slot_back(anchor, 8)])
        begin
            return res;
        end
        first_long = tooth_is_long(anchor);
        pat = {first_long, tooth_is_long(slot_back(anchor, 2)),
               tooth_is_long(slot_back(anchor, 4)), tooth_is_long(slot_back(anchor, 6)),
               tooth_is_long(slot_back(anchor, 8))};
        if (cad_pkg::ILLEGAL_MASK[pat])
        begin
            return res;
        end
        base = tooth_level[anchor] ? BASE_HIGH[pat] : BASE_LOW[pat];
        pd = 4'(base % 15);
        if (pd == 0)
        begin
            pd = first_long ? 4'd12 : 4'd3;
        end
        interval = tooth_time[anchor] - tooth_time[slot_back(anchor, 1)];
        if (interval == 0)
        begin
            return res;
        end
        elapsed = tk - tooth_time[anchor];
        acc = ((64'(elapsed) * 64'(pd)) << FRAC_BITS) / 64'(interval);
        acc = acc + (64'(base) << FRAC_BITS);
        res.angle_q7 = (acc > 64'(cad_pkg::ANGLE_MAX)) ? cad_pkg::ANGLE_MAX : acc[15:0];
        res.angle_valid = 1'b1;
        return res;
    endfunction

    function automatic int draw_wait();
        if (!idle_on || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic push_item(logic rq, logic [31:0] tk, logic lv);
        pending_t p;
        p.item.req_type = rq;
        p.item.tick = tk;
        p.item.level = lv;
        p.drain = 1'b0;
        item_queue.push_back(p);
    endtask

    task automatic push_drain();
        pending_t p;
        p.item = '0;
        p.drain = 1'b1;
        item_queue.push_back(p);
    endtask

    task automatic push_edge(logic [31:0] tk, logic lv);
        push_item(cad_pkg::REQ_EDGE, tk, lv);
        last_edge = tk;
    endtask

    // Emits teeth with optional queries: rising edge, then falling edge after a long or short high time.
    task automatic spin_wheel(int teeth, int query_pct);
        int i;
        int hi;
        for (i = 0; i < teeth; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                period = $urandom_range(0, 7) == 0 ? $urandom_range(4, 2000000) :
                         $urandom_range(8, 5000);
            end
            hi = $urandom_range(0, 1) ? (period * 3) / 4 : period / 4;
            push_edge(wheel_now, 1'b1);
            if ($urandom_range(0, 99) < query_pct)
            begin
                push_item(cad_pkg::REQ_QUERY, wheel_now + $urandom_range(0, hi), 1'($urandom));
            end
            push_edge(wheel_now + hi, 1'b0);
            if ($urandom_range(0, 99) < query_pct)
            begin
                case ($urandom_range(0, 9))
                    0: push_item(cad_pkg::REQ_QUERY, $urandom, 1'($urandom));
                    1: push_item(cad_pkg::REQ_QUERY, last_edge - $urandom_range(0, 3 * period),
                                 1'($urandom));
                    2: push_item(cad_pkg::REQ_QUERY,
                                 last_edge + $urandom_range(0, 32'h7FFF_FFFF), 1'($urandom));
                    default: push_item(cad_pkg::REQ_QUERY,
                                       last_edge + $urandom_range(0, period), 1'($urandom));
                endcase
            end
            wheel_now = wheel_now + period;
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        in_taken = rst_n && in_valid && !in_stall;
        out_taken = rst_n && out_valid && !out_stall;
        if (in_taken)
        begin
            if (in_data.req_type == cad_pkg::REQ_EDGE)
            begin
                head = (head + 1) % RING_DEPTH;
                tooth_time[head] = in_data.tick;
                tooth_level[head] = in_data.level;
                tooth_seen[head] = 1'b1;
                n_edges++;
            end
            else
            begin
                angle_queue.push_back(predict_angle(in_data.tick));
                n_queries++;
            end
        end
        if (out_taken)
        begin
            if (angle_queue.size() == 0)
            begin
                $error("result with no query pending: angle_q7=%0d angle_valid=%0b",
                       out_data.angle_q7, out_data.angle_valid);
                errors++;
            end
            else
            begin
                cad_pkg::out_item_t exp_res;
                exp_res = angle_queue.pop_front();
                if (out_data.angle_q7 !== exp_res.angle_q7)
                begin
                    $error("angle_q7: expected %0d, actual %0d", exp_res.angle_q7,
                           out_data.angle_q7);
                    errors++;
                end
                if (out_data.angle_valid !== exp_res.angle_valid)
                begin
                    $error("angle_valid: expected %0b, actual %0b", exp_res.angle_valid,
                           out_data.angle_valid);
                    errors++;
                end
                if (exp_res.angle_valid)
                begin
                    n_valid++;
                end
                else
                begin
                    n_invalid++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        logic              v;
        cad_pkg::in_item_t d;
        pending_t          nxt;
        v = in_valid;
        d = in_data;
        if (rst_n)
        begin
            if (v && in_taken)
            begin
                v = 1'b0;
                gap_cnt = draw_wait();
                if ($urandom_range(0, 199) == 0)
                begin
                    idle_on = !idle_on;
                end
            end
            if (!v)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                end
                else if (item_queue.size() > 0)
                begin
                    if (item_queue[0].drain)
                    begin
                        if (angle_queue.size() == 0)
                        begin
                            void'(item_queue.pop_front());
                        end
                    end
                    else
                    begin
                        nxt = item_queue.pop_front();
                        d = nxt.item;
                        v = 1'b1;
                    end
                end
            end
            if (out_taken)
            begin
                stall_cnt = draw_wait();
            end
            if (stall_cnt > 0)
            begin
                out_stall <= 1'b1;
                stall_cnt--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
        in_valid <= v;
        in_data <= d;
    end

    initial
    begin
        int   i;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        head = 0;
        for (i = 0; i < RING_DEPTH; i++)
        begin
            tooth_time[i] = '0;
            tooth_level[i] = 1'b0;
            tooth_seen[i] = 1'b0;
        end
        errors = 0;
        cycles = 0;
        gap_cnt = 0;
        stall_cnt = 0;
        idle_on = 1'b1;
        n_edges = 0;
        n_queries = 0;
        n_valid = 0;
        n_invalid = 0;
        period = 1000;

        // Directed part: empty ring, failed search, short history, then a full ring.
        push_item(cad_pkg::REQ_QUERY, 32'h0000_0000, 1'b1);
        push_edge(32'h0000_0000, 1'b1);
        push_item(cad_pkg::REQ_QUERY, 32'hFFFF_FFFF, 1'b0);
        push_item(cad_pkg::REQ_QUERY, 32'h0000_0005, 1'b0);
        wheel_now = 32'd400;
        spin_wheel(3, 0);
        push_item(cad_pkg::REQ_QUERY, last_edge + 10, 1'b0);
        wheel_now = 32'hFFFF_F000;
        spin_wheel(6, 0);
        push_item(cad_pkg::REQ_QUERY, last_edge + 3, 1'b1);
        push_item(cad_pkg::REQ_QUERY, last_edge + 32'h7FFF_FFFF, 1'b0);
        push_item(cad_pkg::REQ_QUERY, last_edge - 32'h7000_0000, 1'b0);
        push_edge(last_edge, 1'b0);
        push_item(cad_pkg::REQ_QUERY, last_edge + 7, 1'b0);
        push_drain();

        while (item_queue.size() < 1450)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                wheel_now = $urandom;
                period = $urandom_range(8, 5000);
            end
            spin_wheel($urandom_range(6, 30), $urandom_range(10, 60));
            if ($urandom_range(0, 7) == 0)
            begin
                push_edge(last_edge, 1'b1);
                push_item(cad_pkg::REQ_QUERY, last_edge + $urandom_range(0, 50), 1'b0);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                push_drain();
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (item_queue.size() == 0 && !in_valid && angle_queue.size() == 0);
        repeat (200) @(posedge clk);
        if (angle_queue.size() != 0)
        begin
            $error("%0d expected results never arrived", angle_queue.size());
            errors++;
        end
        $display("Sent %0d tooth edges and %0d angle queries.", n_edges, n_queries);
        $display("Results: %0d decoded angles, %0d invalid, %0d mismatches.",
                 n_valid, n_invalid, errors);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cad_pkg.sv
rtl/core/cad_divider.sv
rtl/core/crank_24x_angle_decoder.sv
sim/crank_24x_angle_decoder_tb.sv
